// ===== hdl/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int DEF_MAX_LEVELS   = 11;
    localparam int DEF_HEADER_BYTES = 16;

    localparam int OFFSET_W = 26;
    localparam int LEN_W    = 26;
    localparam int ORD_W    = 4;
    localparam int STATUS_W = 2;
    localparam int MINLOG_W = 5;
    localparam int LEVELS_W = 4;
    localparam int REC_W    = 5;

    localparam int MIN_LOG_LO = 5;
    localparam int MIN_LOG_HI = 16;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic REG_MIN_BLOCK_LOG2 = 1'b0;
    localparam logic REG_LEVELS_IN_USE  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [LEN_W-1:0]  length;
        logic [OFFSET_W-1:0] address;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFFSET_W-1:0] block_offset;
        logic [ORD_W-1:0]    block_order;
    } out_item_t;

endpackage

// ===== hdl/buddy_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator with per-node free bits and per-unit order records.
// ----------------------------------------------------------------------------
// Usage: an item on s_ (valid/ready) either allocates (mode 0, length) or
// frees (mode 1, address). Exactly one result item leaves on m_ per input.
// An allocate returns the payload offset (block start plus header) and the
// order, or a no-space status. A free merges with free buddies and returns
// the order reached, or a bad-free status.
// The free bitmap (2^MAX_LEVELS bits) and the order records
// (2^(MAX_LEVELS-1) entries) sit in single-port-write, registered-read
// memories; one item is in work at a time. An allocate scans the blocks of
// the smallest order with a free block one at a time, from position 0 up,
// reading and then checking each bitmap node; a free reads the order
// record, then reads and checks the buddy at each order below the top.
// The next item can be accepted in the cycle after the result is loaded.
// Reset and every register write start a clearing pass over every address
// of both memories, during which s_ready is low.
// A result waits in the output register while m_ready is low; the next
// item is still taken and held once finished until the register empties.
// ----------------------------------------------------------------------------
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int MAX_LEVELS   = DEF_MAX_LEVELS,
    parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NODE_W    = MAX_LEVELS;
    localparam int BLK_W     = MAX_LEVELS - 1;
    localparam int CNT_W     = MAX_LEVELS;
    localparam int MAP_DEPTH = 1 << NODE_W;
    localparam int REC_DEPTH = 1 << BLK_W;

    typedef enum logic [13:0] {
        S_CLEAR     = 14'b00000000000001,
        S_IDLE      = 14'b00000000000010,
        S_DECODE    = 14'b00000000000100,
        S_PICK      = 14'b00000000001000,
        S_SCAN_RD   = 14'b00000000010000,
        S_SCAN_CHK  = 14'b00000000100000,
        S_TAKE      = 14'b00000001000000,
        S_SPLIT     = 14'b00000010000000,
        S_REC       = 14'b00000100000000,
        S_FREE_RD   = 14'b00001000000000,
        S_FREE_CHK  = 14'b00010000000000,
        S_MERGE_RD  = 14'b00100000000000,
        S_MERGE_CHK = 14'b01000000000000,
        S_DONE      = 14'b10000000000000
    } state_t;

    state_t state_reg;

    logic [MINLOG_W-1:0] min_block_log2_reg;
    logic [LEVELS_W-1:0] levels_in_use_reg;

    logic [CNT_W-1:0] count_reg [MAX_LEVELS];

    in_item_t           item_reg;
    out_item_t          res_reg;
    out_item_t          m_data_reg;
    logic               m_valid_reg;
    logic               out_load;
    logic [ORD_W-1:0]   k_reg;
    logic [ORD_W-1:0]   j_reg;
    logic [BLK_W-1:0]   b_reg;
    logic [BLK_W-1:0]   unit_reg;
    logic [NODE_W-1:0]  clr_cnt_reg;

    logic               map_mem [MAP_DEPTH];
    logic [REC_W-1:0]   rec_mem [REC_DEPTH];
    logic               map_rd_data_reg;
    logic [REC_W-1:0]   rec_rd_data_reg;

    logic               map_we;
    logic [NODE_W-1:0]  map_wa;
    logic               map_wd;
    logic [NODE_W-1:0]  map_ra;
    logic               rec_we;
    logic [BLK_W-1:0]   rec_wa;
    logic [REC_W-1:0]   rec_wd;
    logic [BLK_W-1:0]   rec_ra;

    logic               cfg_wr;
    logic [MINLOG_W-1:0] m_eff;
    logic [4:0]         lv_eff;
    logic [ORD_W-1:0]   top;

    // ---------------------------------------------------------------- config
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_block_log2_reg <= MINLOG_W'(5);
            levels_in_use_reg  <= LEVELS_W'(11);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_MIN_BLOCK_LOG2) begin
                min_block_log2_reg <= pwdata[MINLOG_W-1:0];
            end else begin
                levels_in_use_reg <= pwdata[LEVELS_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_LEVELS_IN_USE) begin
            prdata = {{(32-LEVELS_W){1'b0}}, levels_in_use_reg};
        end else begin
            prdata = {{(32-MINLOG_W){1'b0}}, min_block_log2_reg};
        end
    end

    always_comb begin
        if (min_block_log2_reg < MINLOG_W'(MIN_LOG_LO)) begin
            m_eff = MINLOG_W'(MIN_LOG_LO);
        end else if (min_block_log2_reg > MINLOG_W'(MIN_LOG_HI)) begin
            m_eff = MINLOG_W'(MIN_LOG_HI);
        end else begin
            m_eff = min_block_log2_reg;
        end
        if (levels_in_use_reg == '0) begin
            lv_eff = 5'd1;
        end else if ({1'b0, levels_in_use_reg} > 5'(MAX_LEVELS)) begin
            lv_eff = 5'(MAX_LEVELS);
        end else begin
            lv_eff = {1'b0, levels_in_use_reg};
        end
        top = ORD_W'(lv_eff - 5'd1);
    end

    function automatic logic [NODE_W-1:0] node_idx(input logic [ORD_W-1:0] tp,
                                                   input logic [ORD_W-1:0] k,
                                                   input logic [BLK_W-1:0] b);
        logic [ORD_W-1:0] sh;
        sh = tp - k;
        return (NODE_W'(1) << sh) + NODE_W'(b);
    endfunction

    // ---------------------------------------------------------------- decode
    logic [32:0]        need;
    logic               k_found;
    logic [ORD_W-1:0]   k_sel;
    logic               j_found;
    logic [ORD_W-1:0]   j_sel;
    logic               free_bad;
    logic [OFFSET_W-1:0] start;
    logic [31:0]        low_mask;
    logic [OFFSET_W-1:0] unit_full;

    always_comb begin
        need    = 33'(item_reg.length) + 33'(HEADER_BYTES);
        k_found = 1'b0;
        k_sel   = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if (5'(i) < lv_eff &&
                ((33'd1 << (6'(m_eff) + 6'(i))) >= need)) begin
                k_found = 1'b1;
                k_sel   = ORD_W'(i);
            end
        end
    end

    always_comb begin
        j_found = 1'b0;
        j_sel   = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if (5'(i) < lv_eff && ORD_W'(i) >= k_reg && count_reg[i] != '0) begin
                j_found = 1'b1;
                j_sel   = ORD_W'(i);
            end
        end
    end

    always_comb begin
        start     = item_reg.address - OFFSET_W'(HEADER_BYTES);
        low_mask  = (32'd1 << m_eff) - 32'd1;
        unit_full = start >> m_eff;
        free_bad  = (27'(item_reg.address) < 27'(HEADER_BYTES)) ||
                    ((32'(start) & low_mask) != '0) ||
                    (27'(unit_full) >= (27'd1 << (lv_eff - 5'd1)));
    end

    // ---------------------------------------------------------------- datapath
    logic [BLK_W-1:0]   split_b;
    logic [ORD_W-1:0]   rec_k;
    logic [31:0]        alloc_off;

    assign split_b   = b_reg << 1;
    assign rec_k     = ((rec_rd_data_reg - REC_W'(1)) > REC_W'(top)) ?
                       top : ORD_W'(rec_rd_data_reg - REC_W'(1));
    assign alloc_off = (32'(b_reg) << (6'(m_eff) + 6'(k_reg))) + 32'(HEADER_BYTES);

    always_comb begin
        map_we = 1'b0;
        map_wa = '0;
        map_wd = 1'b0;
        map_ra = '0;
        rec_we = 1'b0;
        rec_wa = '0;
        rec_wd = '0;
        rec_ra = unit_reg;
        unique case (state_reg)
            S_CLEAR: begin
                map_we = 1'b1;
                map_wa = clr_cnt_reg;
                map_wd = (clr_cnt_reg == NODE_W'(1));
                rec_we = 1'b1;
                rec_wa = clr_cnt_reg[BLK_W-1:0];
            end
            S_SCAN_RD: begin
                map_ra = node_idx(top, j_reg, b_reg);
            end
            S_TAKE: begin
                map_we = 1'b1;
                map_wa = node_idx(top, j_reg, b_reg);
            end
            S_SPLIT: begin
                map_we = 1'b1;
                map_wa = node_idx(top, j_reg - ORD_W'(1), split_b | BLK_W'(1));
                map_wd = 1'b1;
            end
            S_REC: begin
                rec_we = 1'b1;
                rec_wa = b_reg << k_reg;
                rec_wd = REC_W'(k_reg) + REC_W'(1);
            end
            S_FREE_CHK: begin
                rec_we = (rec_rd_data_reg != '0);
                rec_wa = unit_reg;
            end
            S_MERGE_RD: begin
                map_ra = node_idx(top, j_reg, b_reg ^ BLK_W'(1));
                if (j_reg == top) begin
                    map_we = 1'b1;
                    map_wa = node_idx(top, j_reg, b_reg);
                    map_wd = 1'b1;
                end
            end
            S_MERGE_CHK: begin
                map_we = 1'b1;
                if (map_rd_data_reg) begin
                    map_wa = node_idx(top, j_reg, b_reg ^ BLK_W'(1));
                end else begin
                    map_wa = node_idx(top, j_reg, b_reg);
                    map_wd = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        map_rd_data_reg <= map_mem[map_ra];
    end

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_mem[rec_wa] <= rec_wd;
        end
        rec_rd_data_reg <= rec_mem[rec_ra];
    end

    // ---------------------------------------------------------------- output
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= res_reg;
        end
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                count_reg[i] <= '0;
            end
        end else if (cfg_wr) begin
            // a register write restarts the arena with the new geometry
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + NODE_W'(1);
                    if (clr_cnt_reg == NODE_W'(MAP_DEPTH - 1)) begin
                        for (int i = 0; i < MAX_LEVELS; i++) begin
                            count_reg[i] <= (ORD_W'(i) == top) ? CNT_W'(1) : '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (item_reg.mode == MODE_ALLOC) begin
                        k_reg <= k_sel;
                        if (k_found) begin
                            res_reg   <= '{status: ST_OK, block_offset: '0, block_order: '0};
                            state_reg <= S_PICK;
                        end else begin
                            res_reg   <= '{status: ST_NO_SPACE, block_offset: '0,
                                           block_order: '0};
                            state_reg <= S_DONE;
                        end
                    end else begin
                        unit_reg <= unit_full[BLK_W-1:0];
                        if (free_bad) begin
                            res_reg   <= '{status: ST_BAD_FREE, block_offset: '0,
                                           block_order: '0};
                            state_reg <= S_DONE;
                        end else begin
                            res_reg   <= '{status: ST_OK, block_offset: '0, block_order: '0};
                            state_reg <= S_FREE_RD;
                        end
                    end
                end
                S_PICK: begin
                    j_reg <= j_sel;
                    b_reg <= '0;
                    if (j_found) begin
                        state_reg <= S_SCAN_RD;
                    end else begin
                        res_reg.status <= ST_NO_SPACE;
                        state_reg      <= S_DONE;
                    end
                end
                S_SCAN_RD: begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK: begin
                    if (map_rd_data_reg) begin
                        state_reg <= S_TAKE;
                    end else begin
                        b_reg     <= b_reg + BLK_W'(1);
                        state_reg <= S_SCAN_RD;
                    end
                end
                S_TAKE: begin
                    for (int i = 0; i < MAX_LEVELS; i++) begin
                        if (ORD_W'(i) == j_reg) begin
                            count_reg[i] <= count_reg[i] - CNT_W'(1);
                        end
                    end
                    state_reg <= (j_reg == k_reg) ? S_REC : S_SPLIT;
                end
                S_SPLIT: begin
                    // keep the left half, free the right half
                    for (int i = 0; i < MAX_LEVELS; i++) begin
                        if (ORD_W'(i) == j_reg - ORD_W'(1)) begin
                            count_reg[i] <= count_reg[i] + CNT_W'(1);
                        end
                    end
                    j_reg <= j_reg - ORD_W'(1);
                    b_reg <= split_b;
                    if (j_reg - ORD_W'(1) == k_reg) begin
                        state_reg <= S_REC;
                    end
                end
                S_REC: begin
                    res_reg   <= '{status: ST_OK, block_offset: alloc_off[OFFSET_W-1:0],
                                   block_order: k_reg};
                    state_reg <= S_DONE;
                end
                S_FREE_RD: begin
                    state_reg <= S_FREE_CHK;
                end
                S_FREE_CHK: begin
                    if (rec_rd_data_reg == '0) begin
                        res_reg.status <= ST_BAD_FREE;
                        state_reg      <= S_DONE;
                    end else begin
                        j_reg     <= rec_k;
                        b_reg     <= unit_reg >> rec_k;
                        state_reg <= S_MERGE_RD;
                    end
                end
                S_MERGE_RD: begin
                    if (j_reg == top) begin
                        // top order reached: block was marked free above
                        for (int i = 0; i < MAX_LEVELS; i++) begin
                            if (ORD_W'(i) == j_reg) begin
                                count_reg[i] <= count_reg[i] + CNT_W'(1);
                            end
                        end
                        res_reg.block_order <= j_reg;
                        state_reg           <= S_DONE;
                    end else begin
                        state_reg <= S_MERGE_CHK;
                    end
                end
                S_MERGE_CHK: begin
                    for (int i = 0; i < MAX_LEVELS; i++) begin
                        if (ORD_W'(i) == j_reg) begin
                            count_reg[i] <= map_rd_data_reg ? count_reg[i] - CNT_W'(1)
                                                            : count_reg[i] + CNT_W'(1);
                        end
                    end
                    if (map_rd_data_reg) begin
                        b_reg     <= b_reg >> 1;
                        j_reg     <= j_reg + ORD_W'(1);
                        state_reg <= S_MERGE_RD;
                    end else begin
                        res_reg.block_order <= j_reg;
                        state_reg           <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

endmodule

// ===== bench/buddy_block_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_test
// Self-checking bench for the buddy allocator: a behavioral arena model
// predicts every result item, with random idling on both channels and
// several arena geometries programmed over the register port.
// ----------------------------------------------------------------------------
module buddy_block_allocator_test;
    import bba_pkg::*;

    localparam int LEVELS_MAX = DEF_MAX_LEVELS;
    localparam int HDR        = DEF_HEADER_BYTES;
    localparam int MAP_N      = 1 << LEVELS_MAX;
    localparam int REC_N      = 1 << (LEVELS_MAX - 1);
    localparam logic [2:0] ADDR_MIN_LOG = 3'd0;
    localparam logic [2:0] ADDR_LEVELS  = 3'd4;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    buddy_block_allocator DUT (.*);

    always #1 aclk = ~aclk;

    // arena model
    logic [4:0] cfg_min_log;
    logic [3:0] cfg_levels;
    bit         node_free [MAP_N];
    logic [4:0] unit_order [REC_N];
    out_item_t  expected_q [$];
    logic [25:0] live_offsets [$];
    int errors = 0;
    int results_seen = 0;
    int allocs_ok = 0;
    int frees_ok = 0;
    int rejects = 0;

    function automatic int eff_min();
        if (cfg_min_log < MIN_LOG_LO) return MIN_LOG_LO;
        if (cfg_min_log > MIN_LOG_HI) return MIN_LOG_HI;
        return cfg_min_log;
    endfunction

    function automatic int eff_levels();
        if (cfg_levels < 1) return 1;
        if (cfg_levels > LEVELS_MAX) return LEVELS_MAX;
        return cfg_levels;
    endfunction

    function automatic int node_idx(int lv, int k, int b);
        return ((1 << (lv - 1 - k)) + b) & (MAP_N - 1);
    endfunction

    function automatic void clear_arena();
        for (int i = 0; i < MAP_N; i++) node_free[i] = 0;
        for (int i = 0; i < REC_N; i++) unit_order[i] = '0;
        node_free[1] = 1;
        live_offsets.delete();
    endfunction

    function automatic out_item_t predict_alloc(logic [25:0] len);
        out_item_t r;
        int m, lv, k, j, b;
        longint need;
        bit found;
        m = eff_min();
        lv = eff_levels();
        need = longint'(len) + HDR;
        r = '0;
        r.status = ST_NO_SPACE;
        found = 0;
        b = 0;
        for (k = 0; k < lv; k++)
            if ((64'd1 << (m + k)) >= need) break;
        if (k >= lv) return r;
        for (j = k; j < lv; j++) begin
            for (b = 0; b < (1 << (lv - 1 - j)); b++)
                if (node_free[node_idx(lv, j, b)]) begin
                    found = 1;
                    break;
                end
            if (found) break;
        end
        if (!found) return r;
        node_free[node_idx(lv, j, b)] = 0;
        while (j > k) begin
            j--;
            b = b << 1;
            node_free[node_idx(lv, j, b + 1)] = 1;
        end
        unit_order[(b << k) & (REC_N - 1)] = 5'(k + 1);
        r.status = ST_OK;
        r.block_offset = 26'((longint'(b) << (m + k)) + HDR);
        r.block_order = 4'(k);
        live_offsets.push_back(r.block_offset);
        return r;
    endfunction

    function automatic out_item_t predict_free(logic [25:0] addr);
        out_item_t r;
        int m, lv, k, b;
        longint start, unit;
        m = eff_min();
        lv = eff_levels();
        r = '0;
        r.status = ST_BAD_FREE;
        if (addr < HDR) return r;
        start = longint'(addr) - HDR;
        if ((start & ((64'd1 << m) - 1)) != 0) return r;
        unit = start >> m;
        if (unit >= (64'd1 << (lv - 1))) return r;
        if (unit_order[unit] == 0) return r;
        k = unit_order[unit] - 1;
        unit_order[unit] = '0;
        if (k > lv - 1) k = lv - 1;
        b = int'(unit >> k);
        while (k < lv - 1 && node_free[node_idx(lv, k, b ^ 1)]) begin
            node_free[node_idx(lv, k, b ^ 1)] = 0;
            b = b >> 1;
            k++;
        end
        node_free[node_idx(lv, k, b)] = 1;
        for (int i = 0; i < live_offsets.size(); i++)
            if (live_offsets[i] == addr) begin
                live_offsets.delete(i);
                break;
            end
        r.status = ST_OK;
        r.block_order = 4'(k);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("t=%0t %s: got %0d expected %0d", $time, what, got, want);
        errors++;
    endtask

    task automatic idle_cycles(int n);
        repeat (n) @(posedge aclk);
    endtask

    // send one item; the model runs when it is accepted
    task automatic send_item(logic mode, logic [25:0] len, logic [25:0] addr);
        in_item_t it;
        int gap;
        gap = $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            idle_cycles(gap);
        end
        it.mode = mode;
        it.length = len;
        it.address = addr;
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (mode == MODE_ALLOC) expected_q.push_back(predict_alloc(len));
        else expected_q.push_back(predict_free(addr));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        idle_cycles(60);
    endtask

    task automatic write_reg(logic [2:0] a, logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (a == ADDR_MIN_LOG) cfg_min_log = v[4:0];
        else cfg_levels = v[3:0];
        clear_arena();
        @(posedge aclk);
    endtask

    task automatic set_geometry(logic [4:0] ml, logic [3:0] lv);
        drain();
        write_reg(ADDR_MIN_LOG, 32'(ml));
        write_reg(ADDR_LEVELS, 32'(lv));
    endtask

    // result checker with random stall
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result item status", 32'(m_data.status), 32'(0));
            end else begin
                want = expected_q.pop_front();
                if (m_data.status != want.status)
                    report_mismatch("status", 32'(m_data.status), 32'(want.status));
                if (m_data.block_offset != want.block_offset)
                    report_mismatch("block_offset", 32'(m_data.block_offset),
                                    32'(want.block_offset));
                if (m_data.block_order != want.block_order)
                    report_mismatch("block_order", 32'(m_data.block_order),
                                    32'(want.block_order));
                if (want.status == ST_OK && want.block_offset != 0) allocs_ok++;
                else if (want.status == ST_OK) frees_ok++;
                else rejects++;
            end
        end
    end

    int stall_left = 0;
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic free_random_live();
        int i;
        logic [25:0] a;
        i = $urandom_range(0, live_offsets.size() - 1);
        a = live_offsets[i];
        send_item(MODE_FREE, 26'($urandom()), a);
    endtask

    task automatic test_directed();
        logic [25:0] a;
        send_item(MODE_ALLOC, 26'd0, 26'($urandom()));
        send_item(MODE_ALLOC, 26'd16, 26'h3FFFFFF);
        send_item(MODE_ALLOC, 26'd17, 26'd0);
        send_item(MODE_ALLOC, 26'h3FFFFFF, 26'd0);        // too large
        send_item(MODE_ALLOC, 26'd32752, 26'd0);          // whole arena
        send_item(MODE_FREE, 26'h3FFFFFF, 26'd0);         // below header
        send_item(MODE_FREE, 26'd0, 26'd17);              // misaligned
        send_item(MODE_FREE, 26'd0, 26'h3FFFFF0);         // outside arena
        send_item(MODE_FREE, 26'd0, 26'd16 + 26'd4096);   // never allocated
        while (live_offsets.size() > 0) free_random_live();
        send_item(MODE_FREE, 26'd0, 26'd16);              // double free
        repeat (12) send_item(MODE_ALLOC, 26'($urandom_range(0, 2000)), 26'd0);
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: send_item(MODE_FREE, 26'($urandom()), 26'($urandom()));
                1: send_item(MODE_ALLOC, 26'($urandom()), 26'($urandom()));
                2, 3, 4, 5: begin
                    if (live_offsets.size() > 0) free_random_live();
                    else send_item(MODE_ALLOC, 26'($urandom_range(0, 300)),
                                   26'($urandom()));
                end
                default: send_item(MODE_ALLOC, 26'($urandom_range(0, 1 << $urandom_range(4, 12))),
                                   26'($urandom()));
            endcase
        end
    endtask

    task automatic test_geometries();
        set_geometry(5'd5, 4'd1);
        test_random(60);
        set_geometry(5'd16, 4'd11);
        send_item(MODE_ALLOC, 26'h3FFFFFF, 26'd0);
        send_item(MODE_ALLOC, 26'h3FFFFEF, 26'd0);
        test_random(120);
        set_geometry(5'd31, 4'd15);        // saturates to the extremes
        test_random(80);
        set_geometry(5'd0, 4'd0);
        test_random(60);
        set_geometry(5'd7, 4'd4);
        test_random(300);
        set_geometry(5'd5, 4'd11);
    endtask

    initial begin
        cfg_min_log = 5'd5;
        cfg_levels = 4'd11;
        clear_arena();
        idle_cycles(3);
        aresetn <= 1'b1;
        test_directed();
        test_random(500);
        drain();                            // sender holds off until all results return
        test_random(100);
        test_geometries();
        test_random(500);
        drain();
        $display("covered %0d results: %0d allocations, %0d frees, %0d rejected",
                 results_seen, allocs_ok, frees_ok, rejects);
        if (errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #40000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
